[sv/slle_pkg.sv]
// Shared constants, payload types and link reset values for the linked list engine.
`default_nettype none

package slle_pkg;

  localparam int LIST_SLOTS = 256;
  localparam int SLOT_W     = $clog2(LIST_SLOTS);
  localparam int VALUE_W    = 32;
  localparam int POS_W      = 8;
  localparam int CMD_W      = 4;
  localparam int NUM_W      = 8;

  localparam logic [SLOT_W-1:0] HEAD_SLOT = SLOT_W'(LIST_SLOTS - 1);
  localparam logic [SLOT_W-1:0] FREE_SLOT = '0;
  localparam logic [SLOT_W-1:0] END_LINK  = '0;

  localparam logic [CMD_W-1:0] CMD_INIT   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_EMPTY  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_LENGTH = 4'd3;
  localparam logic [CMD_W-1:0] CMD_GET    = 4'd4;
  localparam logic [CMD_W-1:0] CMD_LOCATE = 4'd5;
  localparam logic [CMD_W-1:0] CMD_PRIOR  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 4'd7;
  localparam logic [CMD_W-1:0] CMD_INSERT = 4'd8;
  localparam logic [CMD_W-1:0] CMD_DELETE = 4'd9;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]          cmd;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } slle_in_t;

  typedef struct packed {
    logic                      status;
    logic signed [VALUE_W-1:0] result_value;
    logic [NUM_W-1:0]          number;
  } slle_out_t;

  typedef struct packed {
    logic              clr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } slle_link_req_t;

  function automatic logic [SLOT_W-1:0] link_reset_value(input logic [SLOT_W-1:0] slot);
    if (slot < SLOT_W'(LIST_SLOTS - 2)) begin
      return slot + SLOT_W'(1);
    end
    return END_LINK;
  endfunction

endpackage

`default_nettype wire

[sv/slle_ram.sv]
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module slle_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[sv/slle_link_mem.sv]
// Link table with per-slot valid bits; clearing them all at once restores the initial chains.
`default_nettype none

module slle_link_mem
  import slle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  slle_link_req_t    req,
  output logic [SLOT_W-1:0] rdata
);

  logic [SLOT_W-1:0]     mem [LIST_SLOTS];
  logic [LIST_SLOTS-1:0] valid_r, valid_nxt;
  logic [SLOT_W-1:0]     data_r;
  logic [SLOT_W-1:0]     raddr_r;
  logic                  hit_r;

  always_comb begin
    valid_nxt = valid_r;
    if (req.clr) begin
      valid_nxt = '0;
    end else if (req.we) begin
      valid_nxt[req.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      hit_r   <= valid_r[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    data_r  <= mem[req.raddr];
    raddr_r <= req.raddr;
  end

  assign rdata = hit_r ? data_r : link_reset_value(raddr_r);

endmodule

`default_nettype wire

[sv/static_linked_list_engine.sv]
// Top level: command sequencer that walks the slot chains through the link and value tables.
// A command is taken when start is high and busy is low; exactly one result follows as a
// one-cycle out_valid strobe that cannot be held off. Init, unknown commands and a zero
// position for get, insert or delete answer in the cycle after the transfer. Every other
// command walks the list one slot per clock, the head slot included, through the read port
// of the link table before the strobe. A value read adds the S_VAL state, delete adds
// S_DEL_RD, S_DEL_J and S_DEL_FREE, and insert adds S_INS_FREE, S_INS_LINK, S_INS_J and
// S_INS_K (only S_INS_FREE when the free chain is empty); clear splices the free chain in
// S_CLR_FREE, then walks the cleared chain to its end. Busy is high outside S_IDLE.
`default_nettype none

module static_linked_list_engine
  import slle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  slle_in_t  in_item,
  output logic      out_valid,
  output slle_out_t out_item
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WALK     = 4'd1;
  localparam logic [3:0] S_VAL      = 4'd2;
  localparam logic [3:0] S_INS_FREE = 4'd3;
  localparam logic [3:0] S_INS_LINK = 4'd4;
  localparam logic [3:0] S_INS_J    = 4'd5;
  localparam logic [3:0] S_INS_K    = 4'd6;
  localparam logic [3:0] S_DEL_RD   = 4'd7;
  localparam logic [3:0] S_DEL_J    = 4'd8;
  localparam logic [3:0] S_DEL_FREE = 4'd9;
  localparam logic [3:0] S_CLR_FREE = 4'd10;
  localparam logic [3:0] S_CLR_WALK = 4'd11;

  logic [3:0]         state_r, state_nxt;
  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [VALUE_W-1:0] val_r, val_nxt;
  logic [SLOT_W-1:0]  cur_r, cur_nxt;
  logic [SLOT_W-1:0]  prev_r, prev_nxt;
  logic [POS_W-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]  slot_k_r, slot_k_nxt;
  logic [SLOT_W-1:0]  link_k_r, link_k_nxt;
  logic [SLOT_W-1:0]  slot_j_r, slot_j_nxt;
  logic [VALUE_W-1:0] hold_r, hold_nxt;
  logic               out_valid_r;
  slle_out_t          out_item_r;

  slle_link_req_t     lk_req;
  logic [SLOT_W-1:0]  lk_rdata;
  logic               vl_we;
  logic [SLOT_W-1:0]  vl_waddr;
  logic [VALUE_W-1:0] vl_wdata;
  logic [SLOT_W-1:0]  vl_raddr;
  logic [VALUE_W-1:0] vl_rdata;

  logic               fin;
  slle_out_t          fin_item;
  logic               adv;
  logic               at_end;
  logic               at_head;
  logic               match;

  slle_link_mem u_link (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (lk_req),
    .rdata (lk_rdata)
  );

  slle_ram #(
    .DEPTH (LIST_SLOTS),
    .WIDTH (VALUE_W)
  ) u_value (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_waddr),
    .wdata (vl_wdata),
    .raddr (vl_raddr),
    .rdata (vl_rdata)
  );

  assign at_end  = (lk_rdata == END_LINK);
  assign at_head = (cur_r == HEAD_SLOT);
  assign match   = (vl_rdata == val_r);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    pos_nxt    = pos_r;
    val_nxt    = val_r;
    cur_nxt    = cur_r;
    prev_nxt   = prev_r;
    cnt_nxt    = cnt_r;
    slot_k_nxt = slot_k_r;
    link_k_nxt = link_k_r;
    slot_j_nxt = slot_j_r;
    hold_nxt   = hold_r;

    lk_req       = '0;
    lk_req.raddr = cur_r;
    vl_we        = 1'b0;
    vl_waddr     = slot_j_r;
    vl_wdata     = val_r;
    vl_raddr     = cur_r;

    fin      = 1'b0;
    fin_item = '0;
    adv      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_item.cmd;
          pos_nxt  = in_item.position;
          val_nxt  = in_item.value;
          cur_nxt  = HEAD_SLOT;
          prev_nxt = HEAD_SLOT;
          cnt_nxt  = '0;
          case (in_item.cmd) inside
            CMD_INIT: begin
              lk_req.clr = 1'b1;
              fin        = 1'b1;
            end
            CMD_GET, CMD_INSERT, CMD_DELETE: begin
              if (in_item.position == '0) begin
                fin             = 1'b1;
                fin_item.status = STATUS_ERR;
              end else begin
                lk_req.raddr = HEAD_SLOT;
                vl_raddr     = HEAD_SLOT;
                state_nxt    = S_WALK;
              end
            end
            CMD_CLEAR, CMD_EMPTY, CMD_LENGTH, CMD_LOCATE, CMD_PRIOR, CMD_NEXT: begin
              lk_req.raddr = HEAD_SLOT;
              vl_raddr     = HEAD_SLOT;
              state_nxt    = S_WALK;
            end
            default: begin
              fin             = 1'b1;
              fin_item.status = STATUS_ERR;
            end
          endcase
        end
      end

      S_WALK: begin
        case (cmd_r) inside
          CMD_CLEAR: begin
            if (at_end) begin
              fin = 1'b1;
            end else begin
              slot_j_nxt   = lk_rdata;
              lk_req.we    = 1'b1;
              lk_req.waddr = HEAD_SLOT;
              lk_req.wdata = END_LINK;
              lk_req.raddr = FREE_SLOT;
              state_nxt    = S_CLR_FREE;
            end
          end
          CMD_EMPTY: begin
            fin             = 1'b1;
            fin_item.number = at_end ? NUM_W'(1) : '0;
          end
          CMD_LENGTH: begin
            if (at_end) begin
              fin             = 1'b1;
              fin_item.number = NUM_W'(cnt_r);
            end else begin
              adv = 1'b1;
            end
          end
          CMD_GET: begin
            if (at_end) begin
              fin             = 1'b1;
              fin_item.status = STATUS_ERR;
            end else if (cnt_r + POS_W'(1) == pos_r) begin
              vl_raddr  = lk_rdata;
              state_nxt = S_VAL;
            end else begin
              adv = 1'b1;
            end
          end
          CMD_LOCATE: begin
            if (!at_head && match) begin
              fin             = 1'b1;
              fin_item.number = NUM_W'(cur_r);
            end else if (at_end) begin
              fin             = 1'b1;
              fin_item.status = STATUS_ERR;
            end else begin
              adv = 1'b1;
            end
          end
          CMD_PRIOR: begin
            if (!at_head && prev_r != HEAD_SLOT && match) begin
              vl_raddr  = prev_r;
              state_nxt = S_VAL;
            end else if (at_end) begin
              fin             = 1'b1;
              fin_item.status = STATUS_ERR;
            end else begin
              prev_nxt = cur_r;
              adv      = 1'b1;
            end
          end
          CMD_NEXT: begin
            if (!at_head && match) begin
              if (at_end) begin
                fin             = 1'b1;
                fin_item.status = STATUS_ERR;
              end else begin
                vl_raddr  = lk_rdata;
                state_nxt = S_VAL;
              end
            end else if (at_end) begin
              fin             = 1'b1;
              fin_item.status = STATUS_ERR;
            end else begin
              adv = 1'b1;
            end
          end
          CMD_INSERT: begin
            if (cnt_r == pos_r - POS_W'(1)) begin
              slot_k_nxt   = cur_r;
              link_k_nxt   = lk_rdata;
              lk_req.raddr = FREE_SLOT;
              state_nxt    = S_INS_FREE;
            end else if (at_end) begin
              fin             = 1'b1;
              fin_item.status = STATUS_ERR;
            end else begin
              adv = 1'b1;
            end
          end
          CMD_DELETE: begin
            if (at_end) begin
              fin             = 1'b1;
              fin_item.status = STATUS_ERR;
            end else if (cnt_r == pos_r - POS_W'(1)) begin
              slot_k_nxt   = cur_r;
              slot_j_nxt   = lk_rdata;
              lk_req.raddr = lk_rdata;
              vl_raddr     = lk_rdata;
              state_nxt    = S_DEL_RD;
            end else begin
              adv = 1'b1;
            end
          end
          default: begin
            fin             = 1'b1;
            fin_item.status = STATUS_ERR;
          end
        endcase
        if (adv) begin
          cur_nxt      = lk_rdata;
          cnt_nxt      = cnt_r + POS_W'(1);
          lk_req.raddr = lk_rdata;
          vl_raddr     = lk_rdata;
        end
      end

      S_VAL: begin
        fin                   = 1'b1;
        fin_item.result_value = vl_rdata;
      end

      S_INS_FREE: begin
        if (at_end) begin
          fin             = 1'b1;
          fin_item.status = STATUS_ERR;
        end else begin
          slot_j_nxt   = lk_rdata;
          lk_req.raddr = lk_rdata;
          state_nxt    = S_INS_LINK;
        end
      end

      S_INS_LINK: begin
        lk_req.we    = 1'b1;
        lk_req.waddr = FREE_SLOT;
        lk_req.wdata = lk_rdata;
        vl_we        = 1'b1;
        state_nxt    = S_INS_J;
      end

      S_INS_J: begin
        lk_req.we    = 1'b1;
        lk_req.waddr = slot_j_r;
        lk_req.wdata = link_k_r;
        state_nxt    = S_INS_K;
      end

      S_INS_K: begin
        lk_req.we    = 1'b1;
        lk_req.waddr = slot_k_r;
        lk_req.wdata = slot_j_r;
        fin          = 1'b1;
      end

      S_DEL_RD: begin
        hold_nxt     = vl_rdata;
        lk_req.we    = 1'b1;
        lk_req.waddr = slot_k_r;
        lk_req.wdata = lk_rdata;
        lk_req.raddr = FREE_SLOT;
        state_nxt    = S_DEL_J;
      end

      S_DEL_J: begin
        lk_req.we    = 1'b1;
        lk_req.waddr = slot_j_r;
        lk_req.wdata = lk_rdata;
        state_nxt    = S_DEL_FREE;
      end

      S_DEL_FREE: begin
        lk_req.we             = 1'b1;
        lk_req.waddr          = FREE_SLOT;
        lk_req.wdata          = slot_j_r;
        fin                   = 1'b1;
        fin_item.result_value = hold_r;
      end

      S_CLR_FREE: begin
        link_k_nxt   = lk_rdata;
        lk_req.we    = 1'b1;
        lk_req.waddr = FREE_SLOT;
        lk_req.wdata = slot_j_r;
        lk_req.raddr = slot_j_r;
        cur_nxt      = slot_j_r;
        state_nxt    = S_CLR_WALK;
      end

      S_CLR_WALK: begin
        if (at_end) begin
          lk_req.we    = 1'b1;
          lk_req.waddr = cur_r;
          lk_req.wdata = link_k_r;
          fin          = 1'b1;
        end else begin
          cur_nxt      = lk_rdata;
          lk_req.raddr = lk_rdata;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    cnt_r    <= cnt_nxt;
    slot_k_r <= slot_k_nxt;
    link_k_r <= link_k_nxt;
    slot_j_r <= slot_j_nxt;
    hold_r   <= hold_nxt;
    if (fin) begin
      out_item_r <= fin_item;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_result_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r != S_IDLE || start))
    else $error("result strobe without a command in progress");

  a_transfer_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither answered nor in progress");

  a_writes_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    lk_req.we |-> (state_r != S_IDLE))
    else $error("link table written while idle");
`endif

endmodule

`default_nettype wire

[tb/slle_tb_pkg.sv]
// Scoreboard for the linked list engine: keeps its own slot table, predicts each answer, checks it.
`timescale 1ns / 1ps

package slle_tb_pkg;
  import slle_pkg::*;

  class list_scoreboard;
    bit [SLOT_W-1:0]  link_tab  [LIST_SLOTS];
    bit [VALUE_W-1:0] value_tab [LIST_SLOTS];
    slle_out_t        awaited_results [$];
    int unsigned      errors;

    function new();
      errors = 0;
      reset_links();
    endfunction

    function void reset_links();
      link_tab[HEAD_SLOT] = END_LINK;
      for (int i = 0; i < LIST_SLOTS - 2; i++) begin
        link_tab[i] = SLOT_W'(i + 1);
      end
      link_tab[LIST_SLOTS - 2] = END_LINK;
    endfunction

    function int unsigned list_len();
      int unsigned n;
      bit [SLOT_W-1:0] i;
      n = 0;
      i = link_tab[HEAD_SLOT];
      while (i != END_LINK && n < LIST_SLOTS) begin
        i = link_tab[i];
        n++;
      end
      return n;
    endfunction

    function bit [SLOT_W-1:0] walk(int unsigned steps);
      bit [SLOT_W-1:0] k;
      k = HEAD_SLOT;
      for (int unsigned l = 0; l < steps; l++) begin
        k = link_tab[k];
      end
      return k;
    endfunction

    function bit [SLOT_W-1:0] find_slot(bit [VALUE_W-1:0] v);
      bit [SLOT_W-1:0] i;
      int unsigned n;
      i = link_tab[HEAD_SLOT];
      n = 0;
      while (i != END_LINK && value_tab[i] != v && n < LIST_SLOTS) begin
        i = link_tab[i];
        n++;
      end
      return (n < LIST_SLOTS) ? i : END_LINK;
    endfunction

    function bit [VALUE_W-1:0] value_at(int unsigned pos);
      return value_tab[walk(pos)];
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    function slle_out_t apply_command(slle_in_t item);
      slle_out_t r;
      bit [SLOT_W-1:0] i, j, k;
      bit [VALUE_W-1:0] v;
      int unsigned n, len, p;
      r = '0;
      v = item.value;
      p = item.position;
      case (item.cmd)
        CMD_INIT: reset_links();
        CMD_CLEAR: begin
          i = link_tab[HEAD_SLOT];
          if (i != END_LINK) begin
            link_tab[HEAD_SLOT] = END_LINK;
            k = link_tab[FREE_SLOT];
            link_tab[FREE_SLOT] = i;
            j = i;
            n = 0;
            while (i != END_LINK && n < LIST_SLOTS) begin
              j = i;
              i = link_tab[i];
              n++;
            end
            link_tab[j] = k;
          end
        end
        CMD_EMPTY: r.number = (link_tab[HEAD_SLOT] == END_LINK) ? NUM_W'(1) : NUM_W'(0);
        CMD_LENGTH: begin
          len = list_len();
          r.number = (len > 255) ? NUM_W'(255) : NUM_W'(len);
        end
        CMD_GET: begin
          if (p < 1 || p > list_len()) r.status = STATUS_ERR;
          else r.result_value = value_tab[walk(p)];
        end
        CMD_LOCATE: begin
          i = find_slot(v);
          if (i == END_LINK) r.status = STATUS_ERR;
          r.number = NUM_W'(i);
        end
        CMD_PRIOR: begin
          j = link_tab[HEAD_SLOT];
          if (j == END_LINK) begin
            r.status = STATUS_ERR;
          end else begin
            i = link_tab[j];
            n = 0;
            while (i != END_LINK && value_tab[i] != v && n < LIST_SLOTS) begin
              j = i;
              i = link_tab[i];
              n++;
            end
            if (i != END_LINK && n < LIST_SLOTS) r.result_value = value_tab[j];
            else r.status = STATUS_ERR;
          end
        end
        CMD_NEXT: begin
          i = find_slot(v);
          j = (i != END_LINK) ? link_tab[i] : END_LINK;
          if (j != END_LINK) r.result_value = value_tab[j];
          else r.status = STATUS_ERR;
        end
        CMD_INSERT: begin
          if (p < 1 || p > list_len() + 1) begin
            r.status = STATUS_ERR;
          end else begin
            j = link_tab[FREE_SLOT];
            if (j == END_LINK) begin
              r.status = STATUS_ERR;
            end else begin
              link_tab[FREE_SLOT] = link_tab[j];
              value_tab[j] = v;
              k = walk(p - 1);
              link_tab[j] = link_tab[k];
              link_tab[k] = j;
            end
          end
        end
        CMD_DELETE: begin
          if (p < 1 || p > list_len()) begin
            r.status = STATUS_ERR;
          end else begin
            k = walk(p - 1);
            j = link_tab[k];
            link_tab[k] = link_tab[j];
            r.result_value = value_tab[j];
            link_tab[j] = link_tab[FREE_SLOT];
            link_tab[FREE_SLOT] = j;
          end
        end
        default: r.status = STATUS_ERR;
      endcase
      return r;
    endfunction

    function void note_command(slle_in_t item);
      awaited_results.push_back(apply_command(item));
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(slle_out_t got);
      slle_out_t exp;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp = awaited_results.pop_front();
      if (got.status !== exp.status)
        report($sformatf("status %0b, predicted %0b", got.status, exp.status));
      if (got.result_value !== exp.result_value)
        report($sformatf("result_value %0d, predicted %0d", got.result_value, exp.result_value));
      if (got.number !== exp.number)
        report($sformatf("number %0d, predicted %0d", got.number, exp.number));
    endtask
  endclass

endpackage

[tb/tb_top.sv]
// Top-level testbench: drives commands in bursts and checks each answer against the scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import slle_pkg::*;
  import slle_tb_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int TAIL_CYCLES  = 300;
  localparam logic [CMD_W-1:0]   CMD_UNKNOWN_TOP = '1;
  localparam logic [VALUE_W-1:0] VAL_MAX    = 32'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_MIN    = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_ONES   = 32'hFFFF_FFFF;
  localparam logic [VALUE_W-1:0] VAL_ABSENT = 32'd12345;

  typedef enum {PH_FILL, PH_CHURN, PH_DRAIN} phase_t;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  slle_in_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  slle_out_t out_item;

  list_scoreboard sb;
  int unsigned    burst_left = 0;
  bit             closing = 1'b0;

  static_linked_list_engine u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) sb.check_result(out_item);
  end

  task automatic send(input logic [CMD_W-1:0] cmd, input int unsigned pos,
                      input logic [VALUE_W-1:0] val);
    slle_in_t item;
    item.cmd      = cmd;
    item.position = POS_W'(pos);
    item.value    = val;
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(item);
    if (closing || burst_left == 0) begin
      start <= 1'b0;
      if (!closing) begin
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12))
          @(posedge clk);
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 10);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic int unsigned pick_pos(int unsigned limit);
    if (limit != 0 && $urandom_range(0, 9) != 0) return $urandom_range(1, limit);
    return $urandom_range(0, 255);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_val(bit from_list);
    int unsigned len;
    len = sb.list_len();
    if (from_list && len != 0) return sb.value_at($urandom_range(1, len));
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 15);
    return $urandom;
  endfunction

  task automatic random_item(input phase_t ph);
    int unsigned len, r, q, ins_w, del_w, pos;
    logic [CMD_W-1:0] cmd;
    logic [VALUE_W-1:0] val;
    len = sb.list_len();
    case (ph)
      PH_FILL: begin
        ins_w = 90;
        del_w = 2;
      end
      PH_DRAIN: begin
        ins_w = 5;
        del_w = 65;
      end
      default: begin
        ins_w = 25;
        del_w = 20;
      end
    endcase
    r = $urandom_range(0, 99);
    if (r < ins_w) begin
      cmd = CMD_INSERT;
      pos = pick_pos(len + 1);
      val = pick_val($urandom_range(0, 6) == 0);
    end else if (r < ins_w + del_w) begin
      cmd = CMD_DELETE;
      pos = pick_pos(len);
      val = $urandom;
    end else begin
      q   = $urandom_range(0, 99);
      pos = pick_pos(len);
      val = pick_val($urandom_range(0, 3) != 0);
      if (q < 3) cmd = CMD_DELETE + CMD_W'($urandom_range(1, 6));
      else if (q < 5 && ph == PH_CHURN) cmd = CMD_INIT;
      else if (q < 7 && ph == PH_CHURN) cmd = CMD_CLEAR;
      else if (q < 15) cmd = CMD_EMPTY;
      else if (q < 25) cmd = CMD_LENGTH;
      else if (q < 45) cmd = CMD_GET;
      else if (q < 65) cmd = CMD_LOCATE;
      else if (q < 80) cmd = CMD_PRIOR;
      else cmd = CMD_NEXT;
    end
    send(cmd, pos, val);
  endtask

  initial begin
    int unsigned sent, phase_left;
    phase_t ph;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(CMD_CLEAR, 0, '0);
    send(CMD_PRIOR, 0, '0);
    send(CMD_EMPTY, 0, '0);
    send(CMD_LENGTH, 0, '0);
    send(CMD_GET, 1, '0);
    send(CMD_DELETE, 1, '0);
    send(CMD_INSERT, 2, VAL_MAX);
    send(CMD_INSERT, 0, VAL_MAX);
    send(CMD_INSERT, 1, VAL_MAX);
    send(CMD_INSERT, 2, VAL_MIN);
    send(CMD_INSERT, 1, '0);
    send(CMD_INSERT, 4, VAL_ONES);
    send(CMD_LENGTH, 0, '0);
    send(CMD_GET, 4, '0);
    send(CMD_GET, 5, '0);
    send(CMD_GET, 255, '0);
    send(CMD_LOCATE, 0, VAL_MIN);
    send(CMD_LOCATE, 0, VAL_ABSENT);
    send(CMD_PRIOR, 0, '0);
    send(CMD_PRIOR, 0, VAL_MIN);
    send(CMD_NEXT, 0, VAL_ONES);
    send(CMD_NEXT, 0, '0);
    send(CMD_DELETE, 2, '0);
    send(CMD_UNKNOWN_TOP, 7, VAL_ONES);
    send(CMD_CLEAR, 0, '0);
    send(CMD_INIT, 0, '0);

    sent       = 0;
    ph         = PH_FILL;
    phase_left = 400;
    while (sent < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        ph         = phase_t'($urandom_range(0, 2));
        phase_left = $urandom_range(40, 250);
      end
      closing = (sent == RANDOM_ITEMS - 1);
      random_item(ph);
      sent++;
      phase_left--;
    end

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("static_linked_list_engine: match");
    end else begin
      $display("static_linked_list_engine: mismatch");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("static_linked_list_engine: mismatch");
    $finish;
  end

endmodule
